>>> hdl/sebs_pkg.sv
// Shared types, constants and helper functions of the sprite edge bevel shader.
package sebs_pkg;

  // Image store geometry.
  localparam int MAX_WIDTH  = 64;
  localparam int MAX_HEIGHT = 64;
  localparam int DEPTH      = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW         = $clog2(DEPTH);
  localparam int IW         = AW + 1;
  localparam int XW         = $clog2(MAX_WIDTH);
  localparam int YW         = $clog2(MAX_HEIGHT);
  localparam int DIM_W      = 7;

  // Field widths.
  localparam int CH_W    = 8;
  localparam int PIX_W   = 3 * CH_W;
  localparam int EDGE_W  = 6;
  localparam int BEVEL_W = 5;
  localparam int DAMP_W  = 6;
  localparam int THICK_W = 7;
  localparam int NUM_W   = CH_W + BEVEL_W;
  localparam int DCNT_W  = $clog2(NUM_W);
  localparam int CFG_IDX_W = 3;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BEVEL    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DAMP     = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_STRENGTH = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KEY      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WIDTH    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT   = 3'd5;

  // Item function codes.
  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_FETCH = 1'b1;

  // Edge map passes.
  localparam logic [2:0] PASS_CLEAR  = 3'd0;
  localparam logic [2:0] PASS_CORNER = 3'd1;
  localparam logic [2:0] PASS_SIDE   = 3'd2;
  localparam logic [2:0] PASS_SLOPE  = 3'd3;
  localparam logic [2:0] PASS_INWARD = 3'd4;

  // Neighborhood slots in the 3x3 window, raster order.
  localparam int NB_N    = 9;
  localparam int NB_W    = $clog2(NB_N);
  localparam int NB_NW   = 0;
  localparam int NB_UP   = 1;
  localparam int NB_LEFT = 3;
  localparam int NB_MID  = 4;
  localparam int NB_RGT  = 5;
  localparam int NB_DN   = 7;
  localparam int NB_SE   = 8;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic build_start;
    logic clr_step;
    logic nb_step;
    logic wr_step;
    logic build_done;
    logic fetch_rd;
    logic mul;
    logic div_step;
    logic out;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic pix_last;
    logic k_last;
    logic pass_final;
    logic div_last;
    logic cfg_hit;
  } sts_t;

  // Column of a window slot: 0 left, 1 center, 2 right.
  function automatic logic [1:0] slot_col(input logic [NB_W-1:0] k);
    logic [1:0] c;
    case (k)
      4'd0, 4'd3, 4'd6: c = 2'd0;
      4'd1, 4'd4, 4'd7: c = 2'd1;
      default:          c = 2'd2;
    endcase
    return c;
  endfunction

  // Row of a window slot: 0 above, 1 center, 2 below.
  function automatic logic [1:0] slot_row(input logic [NB_W-1:0] k);
    logic [1:0] r;
    case (k)
      4'd0, 4'd1, 4'd2: r = 2'd0;
      4'd3, 4'd4, 4'd5: r = 2'd1;
      default:          r = 2'd2;
    endcase
    return r;
  endfunction

  // Slope pass value: bevel / 6 + 1.
  function automatic logic [EDGE_W-1:0] slope_val(input logic [BEVEL_W-1:0] t);
    logic [EDGE_W-1:0] v;
    if (t >= 5'd30)      v = 6'd6;
    else if (t >= 5'd24) v = 6'd5;
    else if (t >= 5'd18) v = 6'd4;
    else if (t >= 5'd12) v = 6'd3;
    else if (t >= 5'd6)  v = 6'd2;
    else                 v = 6'd1;
    return v;
  endfunction

endpackage

>>> hdl/sebs_ctrl.sv
// Controller state machine of the sprite edge bevel shader.
module sebs_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic          func,
  input  sebs_pkg::sts_t sts,
  output sebs_pkg::cmd_t cmd,
  output logic          busy
);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CLR  = 4'd1;
  localparam logic [3:0] S_NB   = 4'd2;
  localparam logic [3:0] S_CAP  = 4'd3;
  localparam logic [3:0] S_WR   = 4'd4;
  localparam logic [3:0] S_FRD  = 4'd5;
  localparam logic [3:0] S_FMUL = 4'd6;
  localparam logic [3:0] S_FDIV = 4'd7;
  localparam logic [3:0] S_FOUT = 4'd8;

  logic [3:0] state_r, state_nxt;
  logic       edges_done_r, edges_done_nxt;

  // Next state and command decode.
  always_comb begin
    cmd            = '0;
    state_nxt      = state_r;
    edges_done_nxt = edges_done_r;
    if (sts.cfg_hit) begin
      edges_done_nxt = 1'b0;
    end
    case (state_r)
      S_IDLE: begin
        if (start) begin
          if (func == sebs_pkg::FUNC_LOAD) begin
            cmd.load       = 1'b1;
            edges_done_nxt = 1'b0;
          end else if (edges_done_r) begin
            state_nxt = S_FRD;
          end else begin
            cmd.build_start = 1'b1;
            state_nxt       = S_CLR;
          end
        end
      end
      S_CLR: begin
        cmd.clr_step = 1'b1;
        if (sts.pix_last) begin
          state_nxt = S_NB;
        end
      end
      S_NB: begin
        cmd.nb_step = 1'b1;
        if (sts.k_last) begin
          state_nxt = S_CAP;
        end
      end
      S_CAP: begin
        state_nxt = S_WR;
      end
      S_WR: begin
        cmd.wr_step = 1'b1;
        if (sts.pix_last && sts.pass_final) begin
          cmd.build_done = 1'b1;
          edges_done_nxt = 1'b1;
          state_nxt      = S_FRD;
        end else begin
          state_nxt = S_NB;
        end
      end
      S_FRD: begin
        cmd.fetch_rd = 1'b1;
        state_nxt    = S_FMUL;
      end
      S_FMUL: begin
        cmd.mul   = 1'b1;
        state_nxt = S_FDIV;
      end
      S_FDIV: begin
        cmd.div_step = 1'b1;
        if (sts.div_last) begin
          state_nxt = S_FOUT;
        end
      end
      S_FOUT: begin
        cmd.out   = 1'b1;
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      edges_done_r <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      edges_done_r <= edges_done_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

endmodule

>>> hdl/sebs_dpath.sv
// Datapath of the sprite edge bevel shader: registers, stores, edge logic and shading.
module sebs_dpath (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sebs_pkg::cmd_t                       cmd,
  output sebs_pkg::sts_t                       sts,
  input  logic                                 cfg_we,
  input  logic [sebs_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [sebs_pkg::PIX_W-1:0]           cfg_data,
  input  logic [sebs_pkg::CH_W-1:0]            in_red_in,
  input  logic [sebs_pkg::CH_W-1:0]            in_green_in,
  input  logic [sebs_pkg::CH_W-1:0]            in_blue_in,
  output logic                                 out_valid,
  output logic [sebs_pkg::CH_W-1:0]            out_red_out,
  output logic [sebs_pkg::CH_W-1:0]            out_green_out,
  output logic [sebs_pkg::CH_W-1:0]            out_blue_out,
  output logic                                 out_last_pixel
);

  localparam int AW     = sebs_pkg::AW;
  localparam int IW     = sebs_pkg::IW;
  localparam int XW     = sebs_pkg::XW;
  localparam int YW     = sebs_pkg::YW;
  localparam int DW     = sebs_pkg::DIM_W;
  localparam int CW     = sebs_pkg::CH_W;
  localparam int EW     = sebs_pkg::EDGE_W;
  localparam int BW     = sebs_pkg::BEVEL_W;
  localparam int TW     = sebs_pkg::THICK_W;
  localparam int NW     = sebs_pkg::NUM_W;
  localparam int KW     = sebs_pkg::NB_W;
  localparam int NBN    = sebs_pkg::NB_N;

  // Configuration registers.
  logic [BW-1:0]                 bevel_r;
  logic [sebs_pkg::DAMP_W-1:0]   damp_r;
  logic [CW-1:0]                 strength_r;
  logic [sebs_pkg::PIX_W-1:0]    key_r;
  logic [DW-1:0]                 width_r;
  logic [DW-1:0]                 height_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bevel_r    <= BW'(4);
      damp_r     <= sebs_pkg::DAMP_W'(4);
      strength_r <= '0;
      key_r      <= sebs_pkg::PIX_W'(24'hFF00FF);
      width_r    <= DW'(64);
      height_r   <= DW'(64);
    end else if (cfg_we) begin
      case (cfg_index)
        sebs_pkg::REG_BEVEL:    bevel_r    <= cfg_data[BW-1:0];
        sebs_pkg::REG_DAMP:     damp_r     <= cfg_data[sebs_pkg::DAMP_W-1:0];
        sebs_pkg::REG_STRENGTH: strength_r <= cfg_data[CW-1:0];
        sebs_pkg::REG_KEY:      key_r      <= cfg_data;
        sebs_pkg::REG_WIDTH:    width_r    <= cfg_data[DW-1:0];
        sebs_pkg::REG_HEIGHT:   height_r   <= cfg_data[DW-1:0];
        default: ;
      endcase
    end
  end

  assign sts.cfg_hit = cfg_we && (cfg_index <= sebs_pkg::REG_HEIGHT);

  // Clamped image size and pixel count.
  logic [DW-1:0] wc, hc;
  logic [IW-1:0] npix, nlast;
  always_comb begin
    if (width_r == '0)                         wc = DW'(1);
    else if (width_r > DW'(sebs_pkg::MAX_WIDTH)) wc = DW'(sebs_pkg::MAX_WIDTH);
    else                                       wc = width_r;
    if (height_r == '0)                          hc = DW'(1);
    else if (height_r > DW'(sebs_pkg::MAX_HEIGHT)) hc = DW'(sebs_pkg::MAX_HEIGHT);
    else                                         hc = height_r;
    npix  = IW'(wc * hc);
    nlast = npix - IW'(1);
  end

  // Shading divisor.
  logic [TW-1:0] thick;
  always_comb begin
    thick = TW'(bevel_r) + TW'(damp_r);
    if (thick == '0) thick = TW'(1);
  end

  // Load and fetch indexes.
  logic [IW-1:0] load_idx_r, fetch_idx_r;
  logic [AW-1:0] load_addr, fetch_addr;
  logic [IW-1:0] fetch_inc;
  always_comb begin
    load_addr  = (load_idx_r >= npix) ? '0 : load_idx_r[AW-1:0];
    fetch_addr = (fetch_idx_r >= npix) ? '0 : fetch_idx_r[AW-1:0];
    fetch_inc  = {1'b0, fetch_addr} + IW'(1);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_idx_r  <= '0;
      fetch_idx_r <= '0;
    end else begin
      if (cmd.load) begin
        load_idx_r  <= {1'b0, load_addr} + IW'(1);
        fetch_idx_r <= '0;
      end else if (cmd.build_done) begin
        load_idx_r <= '0;
      end
      if (cmd.fetch_rd) begin
        fetch_idx_r <= (fetch_inc >= npix) ? '0 : fetch_inc;
      end
    end
  end

  // Edge build scan position and pass.
  logic [AW-1:0] pix_r;
  logic [XW-1:0] x_r;
  logic [YW-1:0] y_r;
  logic [KW-1:0] k_r;
  logic [2:0]    pass_r;
  logic [BW-1:0] step_r;
  logic          pix_last;

  assign pix_last       = ({1'b0, pix_r} == nlast);
  assign sts.pix_last   = pix_last;
  assign sts.k_last     = (k_r == KW'(NBN - 1));
  assign sts.pass_final = ((pass_r == sebs_pkg::PASS_SLOPE) && (bevel_r < BW'(2)))
                       || ((pass_r == sebs_pkg::PASS_INWARD) && (step_r <= BW'(1)));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pass_r <= sebs_pkg::PASS_CLEAR;
      step_r <= '0;
      pix_r  <= '0;
      x_r    <= '0;
      y_r    <= '0;
      k_r    <= '0;
    end else begin
      if (cmd.build_start) begin
        pass_r <= sebs_pkg::PASS_CLEAR;
        pix_r  <= '0;
        x_r    <= '0;
        y_r    <= '0;
        k_r    <= '0;
      end else if (cmd.clr_step || cmd.wr_step) begin
        k_r <= '0;
        if (pix_last) begin
          pix_r <= '0;
          x_r   <= '0;
          y_r   <= '0;
          case (pass_r)
            sebs_pkg::PASS_CLEAR:  pass_r <= sebs_pkg::PASS_CORNER;
            sebs_pkg::PASS_CORNER: pass_r <= sebs_pkg::PASS_SIDE;
            sebs_pkg::PASS_SIDE:   pass_r <= sebs_pkg::PASS_SLOPE;
            sebs_pkg::PASS_SLOPE: begin
              pass_r <= sebs_pkg::PASS_INWARD;
              step_r <= bevel_r - BW'(1);
            end
            default: step_r <= step_r - BW'(1);
          endcase
        end else begin
          pix_r <= pix_r + AW'(1);
          if ({1'b0, x_r} == wc - DW'(1)) begin
            x_r <= '0;
            y_r <= y_r + YW'(1);
          end else begin
            x_r <= x_r + XW'(1);
          end
        end
      end else if (cmd.nb_step) begin
        k_r <= k_r + KW'(1);
      end
    end
  end

  // Neighbor address and image bounds for the current window slot.
  logic [1:0]  col, row;
  logic        nb_in;
  logic [AW:0] nb_sum;
  always_comb begin
    col    = sebs_pkg::slot_col(k_r);
    row    = sebs_pkg::slot_row(k_r);
    nb_in  = 1'b1;
    nb_sum = {1'b0, pix_r};
    if (col == 2'd0) begin
      nb_in  = nb_in && (x_r != '0);
      nb_sum = nb_sum - (AW+1)'(1);
    end else if (col == 2'd2) begin
      nb_in  = nb_in && ((DW'(x_r) + DW'(1)) < wc);
      nb_sum = nb_sum + (AW+1)'(1);
    end
    if (row == 2'd0) begin
      nb_in  = nb_in && (y_r != '0);
      nb_sum = nb_sum - (AW+1)'(wc);
    end else if (row == 2'd2) begin
      nb_in  = nb_in && ((DW'(y_r) + DW'(1)) < hc);
      nb_sum = nb_sum + (AW+1)'(wc);
    end
  end

  // Pixel and edge stores.
  logic [sebs_pkg::PIX_W-1:0] pmem [sebs_pkg::DEPTH];
  logic [EW-1:0]              emem [sebs_pkg::DEPTH];
  logic [sebs_pkg::PIX_W-1:0] pix_q;
  logic [EW-1:0]              edge_q;
  logic [AW-1:0]              rd_addr;
  logic                       e_we;
  logic [EW-1:0]              e_wdata;

  assign rd_addr = cmd.fetch_rd ? fetch_addr : nb_sum[AW-1:0];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      pmem[load_addr] <= {in_red_in, in_green_in, in_blue_in};
    end
    pix_q <= pmem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (e_we) begin
      emem[pix_r] <= e_wdata;
    end
    edge_q <= emem[rd_addr];
  end

  // Window capture: each slot is taken in the cycle after its store read.
  logic            rd_pend_r;
  logic [KW-1:0]   rd_k_r;
  logic            rd_in_r;
  logic            kb_r [NBN];
  logic [EW-1:0]   ed_r [NBN];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= cmd.nb_step;
    end
  end

  always_ff @(posedge clk) begin
    rd_k_r  <= k_r;
    rd_in_r <= nb_in;
    if (rd_pend_r) begin
      kb_r[rd_k_r] <= !rd_in_r || (pix_q == key_r);
      ed_r[rd_k_r] <= rd_in_r ? edge_q : '0;
    end
  end

  // Edge mark decision for the current pass.
  logic          en, lo, hi, diag, interior;
  logic [EW-1:0] mval, sp1, sn1;
  always_comb begin
    en       = 1'b0;
    lo       = 1'b0;
    hi       = 1'b0;
    mval     = EW'(bevel_r);
    diag     = !kb_r[sebs_pkg::NB_NW] && !kb_r[sebs_pkg::NB_SE];
    interior = (x_r != '0) && ((DW'(x_r) + DW'(1)) < wc)
            && (y_r != '0) && ((DW'(y_r) + DW'(1)) < hc);
    sp1      = EW'(step_r) + EW'(1);
    sn1      = EW'(0) - sp1;
    case (pass_r)
      sebs_pkg::PASS_CORNER: begin
        en = !kb_r[sebs_pkg::NB_MID];
        lo = kb_r[sebs_pkg::NB_NW];
        hi = kb_r[sebs_pkg::NB_SE];
      end
      sebs_pkg::PASS_SIDE: begin
        en = !kb_r[sebs_pkg::NB_MID] && (ed_r[sebs_pkg::NB_MID] == '0);
        lo = kb_r[sebs_pkg::NB_LEFT] || kb_r[sebs_pkg::NB_UP] || kb_r[sebs_pkg::NB_NW];
        hi = kb_r[sebs_pkg::NB_RGT] || kb_r[sebs_pkg::NB_DN] || kb_r[sebs_pkg::NB_SE];
      end
      sebs_pkg::PASS_SLOPE: begin
        en   = !kb_r[sebs_pkg::NB_MID] && (ed_r[sebs_pkg::NB_MID] == '0);
        lo   = kb_r[sebs_pkg::NB_UP] && diag;
        hi   = kb_r[sebs_pkg::NB_DN] && diag;
        mval = sebs_pkg::slope_val(bevel_r);
      end
      sebs_pkg::PASS_INWARD: begin
        en   = !kb_r[sebs_pkg::NB_MID] && (ed_r[sebs_pkg::NB_MID] == '0) && interior;
        lo   = (ed_r[sebs_pkg::NB_LEFT] == sp1) || (ed_r[sebs_pkg::NB_UP] == sp1)
            || (ed_r[sebs_pkg::NB_NW] == sp1);
        hi   = (ed_r[sebs_pkg::NB_RGT] == sn1) || (ed_r[sebs_pkg::NB_DN] == sn1)
            || (ed_r[sebs_pkg::NB_SE] == sn1);
        mval = EW'(step_r);
      end
      default: ;
    endcase
    e_we    = cmd.clr_step || (cmd.wr_step && en && (lo != hi));
    e_wdata = cmd.clr_step ? '0 : (lo ? mval : (EW'(0) - mval));
  end

  // Fetch shading: magnitudes of the pull and of the cap, then the division by thick.
  logic          shade_r, neg_r, last_r;
  logic [CW-1:0] base_r [3];
  logic [NW-1:0] num_r  [3];
  logic [TW-1:0] rem_r  [3];
  logic [NW-1:0] capv_r;
  logic [sebs_pkg::DCNT_W-1:0] dcnt_r;
  logic [BW-1:0] labs;
  logic [CW-1:0] chan [3];
  logic          eneg;

  assign eneg    = edge_q[EW-1];
  assign labs    = eneg ? BW'(EW'(0) - edge_q) : edge_q[BW-1:0];
  assign chan[0] = pix_q[3*CW-1:2*CW];
  assign chan[1] = pix_q[2*CW-1:CW];
  assign chan[2] = pix_q[CW-1:0];
  assign sts.div_last = (dcnt_r == sebs_pkg::DCNT_W'(NW - 1));

  always_ff @(posedge clk) begin
    if (cmd.fetch_rd) begin
      last_r <= ({1'b0, fetch_addr} == nlast);
    end
    if (cmd.mul) begin
      shade_r <= (pix_q != key_r) && (edge_q != '0);
      neg_r   <= eneg;
      capv_r  <= NW'(strength_r * labs);
      dcnt_r  <= '0;
      for (int c = 0; c < 3; c++) begin
        base_r[c] <= chan[c];
        rem_r[c]  <= '0;
        num_r[c]  <= NW'((eneg ? chan[c] : (CW'(255) - chan[c])) * labs);
      end
    end else if (cmd.div_step) begin
      dcnt_r <= dcnt_r + sebs_pkg::DCNT_W'(1);
      for (int c = 0; c < 3; c++) begin
        if ({rem_r[c], num_r[c][NW-1]} >= {1'b0, thick}) begin
          rem_r[c] <= TW'({rem_r[c], num_r[c][NW-1]} - {1'b0, thick});
          num_r[c] <= {num_r[c][NW-2:0], 1'b1};
        end else begin
          rem_r[c] <= {rem_r[c][TW-2:0], num_r[c][NW-1]};
          num_r[c] <= {num_r[c][NW-2:0], 1'b0};
        end
      end
    end
  end

  // Final channel values: cap, apply and saturate.
  logic [CW-1:0] res [3];
  logic [NW-1:0] qc  [3];
  logic [NW:0]   sum [3];
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      qc[c]  = ((strength_r != '0) && (num_r[c] > capv_r)) ? capv_r : num_r[c];
      sum[c] = (NW+1)'(base_r[c]) + (NW+1)'(qc[c]);
      if (!shade_r) begin
        res[c] = base_r[c];
      end else if (!neg_r) begin
        res[c] = (sum[c] > (NW+1)'(255)) ? CW'(255) : sum[c][CW-1:0];
      end else begin
        res[c] = (qc[c] > NW'(base_r[c])) ? '0 : CW'(NW'(base_r[c]) - qc[c]);
      end
    end
  end

  // Result registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else begin
      out_valid <= cmd.out;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out) begin
      out_red_out    <= res[0];
      out_green_out  <= res[1];
      out_blue_out   <= res[2];
      out_last_pixel <= last_r;
    end
  end

endmodule

>>> hdl/sprite_edge_bevel_shader_core.sv
// Top level of the sprite edge bevel shader.
// A load item leaves busy low and the next item may follow at
// once. A fetch item keeps busy high until its result appears, one
// cycle wide on out_valid; the result goes through the restoring divider,
// which retires one quotient bit a cycle over 13 bits.
// The first fetch after a load or a register write first rebuilds the edge map:
// a clearing sweep over all N pixels, then a window sweep over them in each of
// 3 + max(bevel_width - 1, 0) passes, N being width times height; each window
// is read from the stores one slot at a time. The receiver cannot stall:
// each result must be taken in the cycle it is shown.
module sprite_edge_bevel_shader_core (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           start,
  output logic                           busy,
  input  logic                           in_func,
  input  logic [sebs_pkg::CH_W-1:0]      in_red_in,
  input  logic [sebs_pkg::CH_W-1:0]      in_green_in,
  input  logic [sebs_pkg::CH_W-1:0]      in_blue_in,
  input  logic                           cfg_we,
  input  logic [sebs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [sebs_pkg::PIX_W-1:0]     cfg_data,
  output logic                           out_valid,
  output logic [sebs_pkg::CH_W-1:0]      out_red_out,
  output logic [sebs_pkg::CH_W-1:0]      out_green_out,
  output logic [sebs_pkg::CH_W-1:0]      out_blue_out,
  output logic                           out_last_pixel
);

  sebs_pkg::cmd_t cmd;
  sebs_pkg::sts_t sts;

  // Sequencer.
  sebs_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .func  (in_func),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy)
  );

  // Stores, edge logic and shading.
  sebs_dpath u_dpath (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .sts            (sts),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_red_in      (in_red_in),
    .in_green_in    (in_green_in),
    .in_blue_in     (in_blue_in),
    .out_valid      (out_valid),
    .out_red_out    (out_red_out),
    .out_green_out  (out_green_out),
    .out_blue_out   (out_blue_out),
    .out_last_pixel (out_last_pixel)
  );

endmodule
